// File: rtl/cci_pkg.sv
// ----------------------------------------------------------------------------
// cci_pkg
// Types, constants and codes for the circle-circle intersection unit.
// ----------------------------------------------------------------------------
`default_nettype none

package cci_pkg;

    localparam int NUM_ANCHORS  = 4;
    localparam int ANCHOR_SLOTS = 4;
    localparam int ANC_W        = 2;
    localparam int SQ_STEPS     = 34;
    localparam int DIV_STEPS    = 16;
    localparam int LANES        = 4;

    localparam logic [15:0] SAT_MAX = 16'h7FFF;
    localparam logic [15:0] SAT_MIN = 16'h8000;

    typedef enum logic [1:0] {
        ST_TWO     = 2'd0,
        ST_TANGENT = 2'd1,
        ST_NONE    = 2'd2,
        ST_SAME    = 2'd3
    } status_t;

    typedef enum logic [2:0] {
        CFG_A0_X = 3'd0,
        CFG_A0_Y = 3'd1,
        CFG_A1_X = 3'd2,
        CFG_A1_Y = 3'd3,
        CFG_A2_X = 3'd4,
        CFG_A2_Y = 3'd5,
        CFG_A3_X = 3'd6,
        CFG_A3_Y = 3'd7
    } cfg_reg_t;

    typedef struct packed {
        logic [15:0]      first_radius;
        logic [15:0]      second_radius;
        logic [ANC_W-1:0] first_anchor;
        logic [ANC_W-1:0] second_anchor;
    } in_t;

    typedef struct packed {
        logic signed [15:0] point_a_x;
        logic signed [15:0] point_a_y;
        logic signed [15:0] point_b_x;
        logic signed [15:0] point_b_y;
        logic [1:0]         fix_status;
    } out_t;

    typedef struct packed {
        logic signed [51:0] bx;
        logic signed [51:0] by;
        logic signed [16:0] dx;
        logic signed [16:0] dy;
        logic [33:0]        d2;
        logic               coin;
        logic               none;
    } side_t;

    typedef struct packed {
        logic coin;
        logic none;
        logic tang;
    } info_t;

endpackage

`default_nettype wire

// File: rtl/cci_ram.sv
// ----------------------------------------------------------------------------
// cci_ram
// Generic RAM: one write port, two registered read ports.
// ----------------------------------------------------------------------------
`default_nettype none

module cci_ram #(
    parameter int WIDTH = 16,
    parameter int DEPTH = 4
) (
    input  wire logic                                   clk,
    input  wire logic                                   we,
    input  wire logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr,
    input  wire logic [WIDTH-1:0]                       wdata,
    input  wire logic                                   re,
    input  wire logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr_a,
    input  wire logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr_b,
    output logic      [WIDTH-1:0]                       rdata_a,
    output logic      [WIDTH-1:0]                       rdata_b
);

    logic [WIDTH-1:0] mem_reg [DEPTH];
    logic [WIDTH-1:0] rdata_a_reg;
    logic [WIDTH-1:0] rdata_b_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem_reg[waddr] <= wdata;
        end
        if (re)
        begin
            rdata_a_reg <= mem_reg[raddr_a];
            rdata_b_reg <= mem_reg[raddr_b];
        end
    end

    assign rdata_a = rdata_a_reg;
    assign rdata_b = rdata_b_reg;

endmodule

`default_nettype wire

// File: rtl/circle_circle_intersection_unit.sv
// ----------------------------------------------------------------------------
// circle_circle_intersection_unit
// Both intersection points of two circles around configured anchors.
// ----------------------------------------------------------------------------
// Takes one beat per cycle while the output is not stalled and returns one
// result beat per input beat, in order. The pipeline holds a pipelined square
// root (34 stages, one root bit per stage) and four pipelined dividers (16
// stages, one quotient bit per stage). A stall on a valid output beat holds
// the whole pipeline and raises in_stall.
// Anchor positions live in two small RAMs; reset clears them to zero through
// per-entry valid bits, so no clearing pass is needed.
// ----------------------------------------------------------------------------
`default_nettype none

module circle_circle_intersection_unit (
    input  wire logic          clk,
    input  wire logic          rst_n,
    input  wire logic          in_valid,
    output logic               in_stall,
    input  wire cci_pkg::in_t  in_data,
    output logic               out_valid,
    input  wire logic          out_stall,
    output cci_pkg::out_t      out_data,
    input  wire logic          cfg_write,
    input  wire logic [2:0]    cfg_index,
    input  wire logic [15:0]   cfg_data
);

    import cci_pkg::*;

    logic en;
    logic out_valid_reg;
    out_t out_data_reg;

    assign en       = !(out_valid_reg && out_stall);
    assign in_stall = !en;

    // configuration
    cfg_reg_t cfg_sel;
    logic     wr_x;
    logic     wr_y;
    logic     ax_vld_reg [ANCHOR_SLOTS];
    logic     ay_vld_reg [ANCHOR_SLOTS];

    assign cfg_sel = cfg_reg_t'(cfg_index);

    always_comb
    begin
        wr_x = 1'b0;
        wr_y = 1'b0;
        if (cfg_write)
        begin
            unique case (cfg_sel) inside
                CFG_A0_X, CFG_A1_X, CFG_A2_X, CFG_A3_X: wr_x = 1'b1;
                CFG_A0_Y, CFG_A1_Y, CFG_A2_Y, CFG_A3_Y: wr_y = 1'b1;
                default: ;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int i = 0; i < ANCHOR_SLOTS; i++)
            begin
                ax_vld_reg[i] <= 1'b0;
                ay_vld_reg[i] <= 1'b0;
            end
        end
        else
        begin
            if (wr_x)
            begin
                ax_vld_reg[cfg_index[2:1]] <= 1'b1;
            end
            if (wr_y)
            begin
                ay_vld_reg[cfg_index[2:1]] <= 1'b1;
            end
        end
    end

    // anchor lookup
    logic [ANC_W-1:0] idx1;
    logic [ANC_W-1:0] idx2;
    logic [15:0]      x1_ram;
    logic [15:0]      y1_ram;
    logic [15:0]      x2_ram;
    logic [15:0]      y2_ram;

    assign idx1 = ({1'b0, in_data.first_anchor} >= (ANC_W+1)'(NUM_ANCHORS))
                ? ANC_W'(NUM_ANCHORS - 1) : in_data.first_anchor;
    assign idx2 = ({1'b0, in_data.second_anchor} >= (ANC_W+1)'(NUM_ANCHORS))
                ? ANC_W'(NUM_ANCHORS - 1) : in_data.second_anchor;

    cci_ram #(.WIDTH(16), .DEPTH(ANCHOR_SLOTS)) u_ram_x (
        .clk     (clk),
        .we      (wr_x),
        .waddr   (cfg_index[2:1]),
        .wdata   (cfg_data),
        .re      (en),
        .raddr_a (idx1),
        .raddr_b (idx2),
        .rdata_a (x1_ram),
        .rdata_b (x2_ram)
    );

    cci_ram #(.WIDTH(16), .DEPTH(ANCHOR_SLOTS)) u_ram_y (
        .clk     (clk),
        .we      (wr_y),
        .waddr   (cfg_index[2:1]),
        .wdata   (cfg_data),
        .re      (en),
        .raddr_a (idx1),
        .raddr_b (idx2),
        .rdata_a (y1_ram),
        .rdata_b (y2_ram)
    );

    // stage a: lookup
    logic        va_reg;
    logic [15:0] r1_a_reg;
    logic [15:0] r2_a_reg;
    logic        v1x_a_reg;
    logic        v1y_a_reg;
    logic        v2x_a_reg;
    logic        v2y_a_reg;

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            r1_a_reg  <= in_data.first_radius;
            r2_a_reg  <= in_data.second_radius;
            v1x_a_reg <= ax_vld_reg[idx1];
            v1y_a_reg <= ay_vld_reg[idx1];
            v2x_a_reg <= ax_vld_reg[idx2];
            v2y_a_reg <= ay_vld_reg[idx2];
        end
    end

    // stage b: differences and sums
    logic signed [15:0] x1;
    logic signed [15:0] y1;
    logic signed [15:0] x2;
    logic signed [15:0] y2;
    logic               vb_reg;
    logic signed [16:0] dx_b_reg;
    logic signed [16:0] dy_b_reg;
    logic signed [16:0] sx_b_reg;
    logic signed [16:0] sy_b_reg;
    logic [16:0]        s_b_reg;
    logic signed [16:0] t_b_reg;
    logic [15:0]        r1_b_reg;
    logic [15:0]        r2_b_reg;

    assign x1 = v1x_a_reg ? $signed(x1_ram) : 16'sd0;
    assign y1 = v1y_a_reg ? $signed(y1_ram) : 16'sd0;
    assign x2 = v2x_a_reg ? $signed(x2_ram) : 16'sd0;
    assign y2 = v2y_a_reg ? $signed(y2_ram) : 16'sd0;

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            dx_b_reg <= 17'(x2) - 17'(x1);
            dy_b_reg <= 17'(y2) - 17'(y1);
            sx_b_reg <= 17'(x1) + 17'(x2);
            sy_b_reg <= 17'(y1) + 17'(y2);
            s_b_reg  <= {1'b0, r1_a_reg} + {1'b0, r2_a_reg};
            t_b_reg  <= $signed({1'b0, r1_a_reg}) - $signed({1'b0, r2_a_reg});
            r1_b_reg <= r1_a_reg;
            r2_b_reg <= r2_a_reg;
        end
    end

    // stage c: squares
    logic               vc_reg;
    logic signed [33:0] dx2_c;
    logic signed [33:0] dy2_c;
    logic signed [33:0] t2_c;
    logic [32:0]        dx2_c_reg;
    logic [32:0]        dy2_c_reg;
    logic [33:0]        s2_c_reg;
    logic [31:0]        t2_c_reg;
    logic [31:0]        r1sq_c_reg;
    logic [31:0]        r2sq_c_reg;
    logic signed [16:0] dx_c_reg;
    logic signed [16:0] dy_c_reg;
    logic signed [16:0] sx_c_reg;
    logic signed [16:0] sy_c_reg;

    assign dx2_c = dx_b_reg * dx_b_reg;
    assign dy2_c = dy_b_reg * dy_b_reg;
    assign t2_c  = t_b_reg * t_b_reg;

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            dx2_c_reg  <= dx2_c[32:0];
            dy2_c_reg  <= dy2_c[32:0];
            s2_c_reg   <= s_b_reg * s_b_reg;
            t2_c_reg   <= t2_c[31:0];
            r1sq_c_reg <= r1_b_reg * r1_b_reg;
            r2sq_c_reg <= r2_b_reg * r2_b_reg;
            dx_c_reg   <= dx_b_reg;
            dy_c_reg   <= dy_b_reg;
            sx_c_reg   <= sx_b_reg;
            sy_c_reg   <= sy_b_reg;
        end
    end

    // stage d: distance and area factors
    logic               vd_reg;
    logic [33:0]        d2_d;
    logic [33:0]        d2_d_reg;
    logic signed [34:0] a_d_reg;
    logic signed [34:0] b_d_reg;
    logic signed [32:0] q_d_reg;
    logic signed [16:0] dx_d_reg;
    logic signed [16:0] dy_d_reg;
    logic signed [16:0] sx_d_reg;
    logic signed [16:0] sy_d_reg;

    assign d2_d = {1'b0, dx2_c_reg} + {1'b0, dy2_c_reg};

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            d2_d_reg <= d2_d;
            a_d_reg  <= $signed({1'b0, s2_c_reg}) - $signed({1'b0, d2_d});
            b_d_reg  <= $signed({1'b0, d2_d}) - $signed({3'b0, t2_c_reg});
            q_d_reg  <= $signed({1'b0, r1sq_c_reg}) - $signed({1'b0, r2sq_c_reg});
            dx_d_reg <= dx_c_reg;
            dy_d_reg <= dy_c_reg;
            sx_d_reg <= sx_c_reg;
            sy_d_reg <= sy_c_reg;
        end
    end

    // stage e: partial products
    logic               ve_reg;
    logic [33:0]        pp0_e_reg;
    logic [33:0]        pp1_e_reg;
    logic [33:0]        pp2_e_reg;
    logic [33:0]        pp3_e_reg;
    logic signed [49:0] ppx0_e_reg;
    logic signed [19:0] ppx1_e_reg;
    logic signed [49:0] ppqx_e_reg;
    logic signed [49:0] ppy0_e_reg;
    logic signed [19:0] ppy1_e_reg;
    logic signed [49:0] ppqy_e_reg;
    logic               q32_e_reg;
    logic signed [16:0] dx_e_reg;
    logic signed [16:0] dy_e_reg;
    logic [33:0]        d2_e_reg;
    logic               coin_e_reg;
    logic               none_e_reg;

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            pp0_e_reg  <= a_d_reg[16:0]  * b_d_reg[16:0];
            pp1_e_reg  <= a_d_reg[16:0]  * b_d_reg[33:17];
            pp2_e_reg  <= a_d_reg[33:17] * b_d_reg[16:0];
            pp3_e_reg  <= a_d_reg[33:17] * b_d_reg[33:17];
            ppx0_e_reg <= sx_d_reg * $signed({1'b0, d2_d_reg[31:0]});
            ppx1_e_reg <= sx_d_reg * $signed({1'b0, d2_d_reg[33:32]});
            ppqx_e_reg <= dx_d_reg * $signed({1'b0, q_d_reg[31:0]});
            ppy0_e_reg <= sy_d_reg * $signed({1'b0, d2_d_reg[31:0]});
            ppy1_e_reg <= sy_d_reg * $signed({1'b0, d2_d_reg[33:32]});
            ppqy_e_reg <= dy_d_reg * $signed({1'b0, q_d_reg[31:0]});
            q32_e_reg  <= q_d_reg[32];
            dx_e_reg   <= dx_d_reg;
            dy_e_reg   <= dy_d_reg;
            d2_e_reg   <= d2_d_reg;
            coin_e_reg <= (d2_d_reg == '0);
            none_e_reg <= a_d_reg[34] || b_d_reg[34];
        end
    end

    // stage f: area product and base numerators, into the root pipeline
    logic [67:0]        p_f;
    logic signed [51:0] bx_f;
    logic signed [51:0] by_f;
    logic signed [51:0] qx_hi_f;
    logic signed [51:0] qy_hi_f;
    side_t              side_f;

    assign p_f = {34'b0, pp0_e_reg} + {17'b0, pp1_e_reg, 17'b0}
               + {17'b0, pp2_e_reg, 17'b0} + {pp3_e_reg, 34'b0};

    assign qx_hi_f = q32_e_reg ? $signed({{3{dx_e_reg[16]}}, dx_e_reg, 32'b0}) : 52'sd0;
    assign qy_hi_f = q32_e_reg ? $signed({{3{dy_e_reg[16]}}, dy_e_reg, 32'b0}) : 52'sd0;

    assign bx_f = 52'(ppx0_e_reg) + $signed({ppx1_e_reg, 32'b0})
                + 52'(ppqx_e_reg) - qx_hi_f;
    assign by_f = 52'(ppy0_e_reg) + $signed({ppy1_e_reg, 32'b0})
                + 52'(ppqy_e_reg) - qy_hi_f;

    always_comb
    begin
        side_f.bx   = bx_f;
        side_f.by   = by_f;
        side_f.dx   = dx_e_reg;
        side_f.dy   = dy_e_reg;
        side_f.d2   = d2_e_reg;
        side_f.coin = coin_e_reg;
        side_f.none = none_e_reg;
    end

    // square root, one result bit per stage
    logic        sq_vld_reg  [SQ_STEPS+1];
    logic [67:0] sq_p_reg    [SQ_STEPS+1];
    logic [35:0] sq_rem_reg  [SQ_STEPS+1];
    logic [33:0] sq_root_reg [SQ_STEPS+1];
    side_t       sq_side_reg [SQ_STEPS+1];

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            sq_p_reg[0]    <= p_f;
            sq_rem_reg[0]  <= '0;
            sq_root_reg[0] <= '0;
            sq_side_reg[0] <= side_f;
        end
    end

    for (genvar k = 1; k <= SQ_STEPS; k++)
    begin : g_sqrt
        logic [37:0] rem_try;
        logic [37:0] trial;
        logic        ge;
        logic [35:0] rem_next;
        logic [33:0] root_next;

        assign rem_try   = {sq_rem_reg[k-1], sq_p_reg[k-1][67:66]};
        assign trial     = {2'b0, sq_root_reg[k-1], 2'b01};
        assign ge        = (rem_try >= trial);
        assign rem_next  = ge ? 36'(rem_try - trial) : rem_try[35:0];
        assign root_next = {sq_root_reg[k-1][32:0], ge};

        always_ff @(posedge clk)
        begin
            if (en)
            begin
                sq_p_reg[k]    <= {sq_p_reg[k-1][65:0], 2'b00};
                sq_rem_reg[k]  <= rem_next;
                sq_root_reg[k] <= root_next;
                sq_side_reg[k] <= sq_side_reg[k-1];
            end
        end
    end

    // stage h: offset partial products
    logic               vh_reg;
    logic [33:0]        h_sq;
    side_t              side_sq;
    logic signed [49:0] ppdy0_h_reg;
    logic signed [19:0] ppdy1_h_reg;
    logic signed [49:0] ppdx0_h_reg;
    logic signed [19:0] ppdx1_h_reg;
    logic signed [51:0] bx_h_reg;
    logic signed [51:0] by_h_reg;
    logic [33:0]        d2_h_reg;
    info_t              info_h_reg;

    assign h_sq    = sq_root_reg[SQ_STEPS];
    assign side_sq = sq_side_reg[SQ_STEPS];

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            ppdy0_h_reg     <= side_sq.dy * $signed({1'b0, h_sq[31:0]});
            ppdy1_h_reg     <= side_sq.dy * $signed({1'b0, h_sq[33:32]});
            ppdx0_h_reg     <= side_sq.dx * $signed({1'b0, h_sq[31:0]});
            ppdx1_h_reg     <= side_sq.dx * $signed({1'b0, h_sq[33:32]});
            bx_h_reg        <= side_sq.bx;
            by_h_reg        <= side_sq.by;
            d2_h_reg        <= side_sq.d2;
            info_h_reg.coin <= side_sq.coin;
            info_h_reg.none <= side_sq.none;
            info_h_reg.tang <= (h_sq == '0);
        end
    end

    // stage i: offsets
    logic               vi_reg;
    logic signed [51:0] dyh_i_reg;
    logic signed [51:0] dxh_i_reg;
    logic signed [51:0] bx_i_reg;
    logic signed [51:0] by_i_reg;
    logic [33:0]        d2_i_reg;
    info_t              info_i_reg;

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            dyh_i_reg  <= 52'(ppdy0_h_reg) + $signed({ppdy1_h_reg, 32'b0});
            dxh_i_reg  <= 52'(ppdx0_h_reg) + $signed({ppdx1_h_reg, 32'b0});
            bx_i_reg   <= bx_h_reg;
            by_i_reg   <= by_h_reg;
            d2_i_reg   <= d2_h_reg;
            info_i_reg <= info_h_reg;
        end
    end

    // stage j: numerators
    logic               vj_reg;
    logic signed [52:0] n_j_reg [LANES];
    logic [33:0]        d2_j_reg;
    info_t              info_j_reg;

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            n_j_reg[0] <= 53'(bx_i_reg) - 53'(dyh_i_reg);
            n_j_reg[1] <= 53'(by_i_reg) + 53'(dxh_i_reg);
            n_j_reg[2] <= 53'(bx_i_reg) + 53'(dyh_i_reg);
            n_j_reg[3] <= 53'(by_i_reg) - 53'(dxh_i_reg);
            d2_j_reg   <= d2_i_reg;
            info_j_reg <= info_i_reg;
        end
    end

    // stage k: rounding bias and offset into the unsigned quotient range
    logic               vk_reg;
    logic signed [54:0] m_k_reg [LANES];
    logic [33:0]        d2_k_reg;
    info_t              info_k_reg;

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            for (int l = 0; l < LANES; l++)
            begin
                m_k_reg[l] <= $signed({n_j_reg[l][52], n_j_reg[l], 1'b0})
                            + $signed({4'b0, d2_j_reg, 17'b0})
                            + $signed({20'b0, d2_j_reg, 1'b0});
            end
            d2_k_reg   <= d2_j_reg;
            info_k_reg <= info_j_reg;
        end
    end

    // divider, one quotient bit per stage
    logic        dv_vld_reg [DIV_STEPS+1];
    logic [51:0] dv_rem_reg [DIV_STEPS+1][LANES];
    logic [15:0] dv_q_reg   [DIV_STEPS+1][LANES];
    logic        dv_lo_reg  [DIV_STEPS+1][LANES];
    logic        dv_hi_reg  [DIV_STEPS+1][LANES];
    logic [35:0] dv_d_reg   [DIV_STEPS+1];
    info_t       dv_info_reg[DIV_STEPS+1];

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            for (int l = 0; l < LANES; l++)
            begin
                dv_lo_reg[0][l]  <= m_k_reg[l][54];
                dv_hi_reg[0][l]  <= !m_k_reg[l][54]
                                 && (m_k_reg[l][53:0] >= {2'b0, d2_k_reg, 18'b0});
                dv_rem_reg[0][l] <= (m_k_reg[l][54]
                                 || (m_k_reg[l][53:0] >= {2'b0, d2_k_reg, 18'b0}))
                                 ? '0 : m_k_reg[l][51:0];
                dv_q_reg[0][l]   <= '0;
            end
            dv_d_reg[0]    <= {d2_k_reg, 2'b00};
            dv_info_reg[0] <= info_k_reg;
        end
    end

    for (genvar j = 1; j <= DIV_STEPS; j++)
    begin : g_div
        logic [51:0] dsh;

        assign dsh = 52'(dv_d_reg[j-1]) << (DIV_STEPS - j);

        for (genvar l = 0; l < LANES; l++)
        begin : g_lane
            logic        ge;
            logic [51:0] rem_next;

            assign ge       = (dv_rem_reg[j-1][l] >= dsh);
            assign rem_next = ge ? (dv_rem_reg[j-1][l] - dsh) : dv_rem_reg[j-1][l];

            always_ff @(posedge clk)
            begin
                if (en)
                begin
                    dv_rem_reg[j][l] <= rem_next;
                    dv_q_reg[j][l]   <= {dv_q_reg[j-1][l][14:0], ge};
                    dv_lo_reg[j][l]  <= dv_lo_reg[j-1][l];
                    dv_hi_reg[j][l]  <= dv_hi_reg[j-1][l];
                end
            end
        end

        always_ff @(posedge clk)
        begin
            if (en)
            begin
                dv_d_reg[j]    <= dv_d_reg[j-1];
                dv_info_reg[j] <= dv_info_reg[j-1];
            end
        end
    end

    // output stage
    logic [15:0] pt   [LANES];
    info_t       info_o;
    status_t     st_o;
    out_t        out_next;

    assign info_o = dv_info_reg[DIV_STEPS];

    always_comb
    begin
        for (int l = 0; l < LANES; l++)
        begin
            if (info_o.coin || info_o.none)
            begin
                pt[l] = '0;
            end
            else if (dv_hi_reg[DIV_STEPS][l])
            begin
                pt[l] = SAT_MAX;
            end
            else if (dv_lo_reg[DIV_STEPS][l])
            begin
                pt[l] = SAT_MIN;
            end
            else
            begin
                pt[l] = {~dv_q_reg[DIV_STEPS][l][15], dv_q_reg[DIV_STEPS][l][14:0]};
            end
        end
        if (info_o.coin)
        begin
            st_o = ST_SAME;
        end
        else if (info_o.none)
        begin
            st_o = ST_NONE;
        end
        else if (info_o.tang)
        begin
            st_o = ST_TANGENT;
        end
        else
        begin
            st_o = ST_TWO;
        end
        out_next.point_a_x  = $signed(pt[0]);
        out_next.point_a_y  = $signed(pt[1]);
        out_next.point_b_x  = $signed(pt[2]);
        out_next.point_b_y  = $signed(pt[3]);
        out_next.fix_status = st_o;
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            out_data_reg <= out_next;
        end
    end

    // valid bits
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            va_reg        <= 1'b0;
            vb_reg        <= 1'b0;
            vc_reg        <= 1'b0;
            vd_reg        <= 1'b0;
            ve_reg        <= 1'b0;
            vh_reg        <= 1'b0;
            vi_reg        <= 1'b0;
            vj_reg        <= 1'b0;
            vk_reg        <= 1'b0;
            out_valid_reg <= 1'b0;
            for (int k = 0; k <= SQ_STEPS; k++)
            begin
                sq_vld_reg[k] <= 1'b0;
            end
            for (int j = 0; j <= DIV_STEPS; j++)
            begin
                dv_vld_reg[j] <= 1'b0;
            end
        end
        else if (en)
        begin
            va_reg        <= in_valid;
            vb_reg        <= va_reg;
            vc_reg        <= vb_reg;
            vd_reg        <= vc_reg;
            ve_reg        <= vd_reg;
            sq_vld_reg[0] <= ve_reg;
            for (int k = 1; k <= SQ_STEPS; k++)
            begin
                sq_vld_reg[k] <= sq_vld_reg[k-1];
            end
            vh_reg        <= sq_vld_reg[SQ_STEPS];
            vi_reg        <= vh_reg;
            vj_reg        <= vi_reg;
            vk_reg        <= vj_reg;
            dv_vld_reg[0] <= vk_reg;
            for (int j = 1; j <= DIV_STEPS; j++)
            begin
                dv_vld_reg[j] <= dv_vld_reg[j-1];
            end
            out_valid_reg <= dv_vld_reg[DIV_STEPS];
        end
    end

    assign out_valid = out_valid_reg;
    assign out_data  = out_data_reg;

    // checks
    a_tangent_same_point : assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && out_data.fix_status == ST_TANGENT |->
            out_data.point_a_x == out_data.point_b_x
            && out_data.point_a_y == out_data.point_b_y)
        else $error("tangent result with two distinct points");

    a_no_fix_zero : assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && (out_data.fix_status == ST_SAME || out_data.fix_status == ST_NONE) |->
            out_data.point_a_x == '0 && out_data.point_a_y == '0
            && out_data.point_b_x == '0 && out_data.point_b_y == '0)
        else $error("points not cleared without an intersection");

    a_last_div_to_out : assert property (@(posedge clk) disable iff (!rst_n)
        en && dv_vld_reg[DIV_STEPS] |=> out_valid)
        else $error("divider beat lost before output");

    a_root_remainder : assert property (@(posedge clk) disable iff (!rst_n)
        sq_vld_reg[SQ_STEPS] |->
            sq_rem_reg[SQ_STEPS] <= {1'b0, sq_root_reg[SQ_STEPS], 1'b0})
        else $error("square root remainder out of range");

    a_div_remainder : assert property (@(posedge clk) disable iff (!rst_n)
        dv_vld_reg[DIV_STEPS] && !dv_info_reg[DIV_STEPS].coin
        && !dv_hi_reg[DIV_STEPS][0] && !dv_lo_reg[DIV_STEPS][0] |->
            dv_rem_reg[DIV_STEPS][0] < 52'(dv_d_reg[DIV_STEPS]))
        else $error("divider remainder not below divisor");

endmodule

`default_nettype wire

// File: bench/tb_circle_circle_intersection_unit.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_circle_circle_intersection_unit
// Two-circle intersection points against a bit-exact local predictor.
// Configures anchor positions while idle, sends directed radius pairs and
// then random ones with random gaps and output stalls, and checks each result
// beat in order against the predicted points and status.
// ----------------------------------------------------------------------------
`default_nettype none

module tb_circle_circle_intersection_unit;
    import cci_pkg::*;

    localparam int LATENCY    = 61;
    localparam int WDOG_LIMIT = 20000;
    localparam int DUE_DEPTH  = 4096;

    logic         clk;
    logic         rst_n;
    logic         in_valid;
    logic         in_stall;
    in_t          in_data;
    logic         out_valid;
    logic         out_stall;
    out_t         out_data;
    logic         cfg_write;
    logic [2:0]   cfg_index;
    logic [15:0]  cfg_data;

    logic signed [15:0] anchor_x [4];
    logic signed [15:0] anchor_y [4];
    out_t         points_due [DUE_DEPTH];
    int           due_wr;
    int           due_rd;
    int           mismatches;
    int           idle_cycles;
    bit           hold_off;
    bit           stall_enable;

    circle_circle_intersection_unit u_top (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_stall  (in_stall),
        .in_data   (in_data),
        .out_valid (out_valid),
        .out_stall (out_stall),
        .out_data  (out_data),
        .cfg_write (cfg_write),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    always #4 clk = ~clk;

    function automatic logic [15:0] round_saturate(longint num, longint den);
        longint n;
        longint d;
        longint q;
        n = 2 * num + den;
        d = 2 * den;
        q = n / d;
        if ((n % d) != 0 && n < 0)
        begin
            q--;
        end
        if (q > 32767)
        begin
            q = 32767;
        end
        if (q < -32768)
        begin
            q = -32768;
        end
        return q[15:0];
    endfunction

    function automatic longint isqrt_product(longint a, longint b);
        logic [127:0] prod;
        logic [127:0] cand;
        longint root;
        prod = 128'(a) * 128'(b);
        root = 0;
        for (int bitpos = 36; bitpos >= 0; bitpos--)
        begin
            cand = 128'(root | (longint'(1) << bitpos));
            if (cand * cand <= prod)
            begin
                root = longint'(cand);
            end
        end
        return root;
    endfunction

    function automatic out_t intersect_points(in_t beat);
        out_t   res;
        longint r1, r2, x1, y1, x2, y2, dx, dy, d2, s, t, a, b, h, q, den, bx, by;
        res = '0;
        r1 = beat.first_radius;
        r2 = beat.second_radius;
        x1 = anchor_x[beat.first_anchor];
        y1 = anchor_y[beat.first_anchor];
        x2 = anchor_x[beat.second_anchor];
        y2 = anchor_y[beat.second_anchor];
        dx = x2 - x1;
        dy = y2 - y1;
        d2 = dx * dx + dy * dy;
        if (d2 == 0)
        begin
            res.fix_status = ST_SAME;
            return res;
        end
        s = r1 + r2;
        t = r1 - r2;
        a = s * s - d2;
        b = d2 - t * t;
        if (a < 0 || b < 0)
        begin
            res.fix_status = ST_NONE;
            return res;
        end
        h = isqrt_product(a, b);
        q = r1 * r1 - r2 * r2;
        den = 2 * d2;
        bx = (x1 + x2) * d2 + dx * q;
        by = (y1 + y2) * d2 + dy * q;
        res.point_a_x = round_saturate(bx - dy * h, den);
        res.point_a_y = round_saturate(by + dx * h, den);
        res.point_b_x = round_saturate(bx + dy * h, den);
        res.point_b_y = round_saturate(by - dx * h, den);
        res.fix_status = (h == 0) ? ST_TANGENT : ST_TWO;
        return res;
    endfunction

    function automatic int random_gap();
        if ($urandom_range(0, 2) == 0)
        begin
            return 0;
        end
        if ($urandom_range(0, 19) == 0)
        begin
            return $urandom_range(10, 40);
        end
        return $urandom_range(1, 3);
    endfunction

    task automatic report_mismatch(string what, longint got, longint want);
        $display("mismatch %s: got %0d expected %0d", what, got, want);
        mismatches++;
    endtask

    task automatic send_beat(in_t beat, bit gaps = 1);
        int gap;
        gap = gaps ? random_gap() : 0;
        if (gap > 0)
        begin
            in_valid <= 1'b0;
            repeat (gap)
            begin
                @(negedge clk);
            end
        end
        in_valid <= 1'b1;
        in_data  <= beat;
        @(posedge clk);
        while (in_stall)
        begin
            @(posedge clk);
        end
        points_due[due_wr] = intersect_points(beat);
        due_wr++;
        @(negedge clk);
    endtask

    task automatic write_anchor(int idx, logic [15:0] x, logic [15:0] y);
        cfg_write <= 1'b1;
        cfg_index <= 3'(2 * idx);
        cfg_data  <= x;
        @(negedge clk);
        cfg_index <= 3'(2 * idx + 1);
        cfg_data  <= y;
        @(negedge clk);
        anchor_x[idx] = x;
        anchor_y[idx] = y;
    endtask

    task automatic wait_drained();
        in_valid <= 1'b0;
        while (due_wr != due_rd)
        begin
            @(negedge clk);
        end
        repeat (LATENCY + 4)
        begin
            @(negedge clk);
        end
    endtask

    function automatic in_t random_beat();
        in_t    beat;
        longint dx, dy, span;
        beat.first_anchor  = 2'($urandom_range(0, 3));
        beat.second_anchor = 2'($urandom_range(0, 3));
        dx = anchor_x[beat.second_anchor] - anchor_x[beat.first_anchor];
        dy = anchor_y[beat.second_anchor] - anchor_y[beat.first_anchor];
        span = 0;
        while (span * span < dx * dx + dy * dy)
        begin
            span++;
        end
        if ($urandom_range(0, 3) != 0 && span > 0 && span < 60000)
        begin
            // radii around a real crossing
            beat.first_radius  = 16'($urandom_range(32'(span / 8), 32'(span)));
            beat.second_radius = 16'($urandom_range(32'(span - beat.first_radius),
                                 32'(span + beat.first_radius)) & 16'hFFFF);
        end
        else
        begin
            beat.first_radius  = 16'($urandom);
            beat.second_radius = 16'($urandom);
        end
        return beat;
    endfunction

    task automatic test_directed();
        write_anchor(0, 16'sd0, 16'sd0);
        write_anchor(1, 16'sd1280, 16'sd0);
        write_anchor(2, 16'h7FFF, 16'h7FFF);
        write_anchor(3, 16'h8000, 16'h8000);
        cfg_write <= 1'b0;
        send_beat('{16'd1024, 16'd1024, 2'd0, 2'd1}, 0);
        send_beat('{16'd512, 16'd768, 2'd0, 2'd1}, 0);
        send_beat('{16'd256, 16'd256, 2'd0, 2'd1}, 0);
        send_beat('{16'd640, 16'd640, 2'd0, 2'd1}, 0);
        send_beat('{16'd100, 16'd200, 2'd2, 2'd2}, 0);
        send_beat('{16'hFFFF, 16'hFFFF, 2'd2, 2'd3}, 0);
        send_beat('{16'hFFFF, 16'hFFFF, 2'd3, 2'd2}, 0);
        send_beat('{16'hFFFF, 16'd0, 2'd0, 2'd3}, 0);
        send_beat('{16'd0, 16'd0, 2'd0, 2'd1}, 0);
        send_beat('{16'd0, 16'd1280, 2'd0, 2'd1}, 0);
        send_beat('{16'hFFFF, 16'hFFFF, 2'd0, 2'd1}, 0);
        send_beat('{16'h5555, 16'hAAAA, 2'd1, 2'd0}, 0);
        send_beat('{16'hAAAA, 16'h5555, 2'd3, 2'd0}, 0);
        send_beat('{16'd46341, 16'd46341, 2'd0, 2'd2}, 0);
        wait_drained();
    endtask

    task automatic test_random(int phases, int per_phase);
        for (int p = 0; p < phases; p++)
        begin
            for (int i = 0; i < 4; i++)
            begin
                if (p % 3 == 0)
                begin
                    write_anchor(i, 16'($urandom_range(0, 4095) - 2048),
                                 16'($urandom_range(0, 4095) - 2048));
                end
                else
                begin
                    write_anchor(i, 16'($urandom), 16'($urandom));
                end
            end
            cfg_write <= 1'b0;
            for (int i = 0; i < per_phase; i++)
            begin
                send_beat(random_beat());
            end
            wait_drained();
        end
    endtask

    task automatic test_backpressure();
        hold_off = 1'b1;
        for (int i = 0; i < 150; i++)
        begin
            send_beat(random_beat(), 0);
        end
        wait_drained();
    endtask

    // result checker
    always @(posedge clk)
    begin
        out_t want;
        if (rst_n && out_valid && !out_stall)
        begin
            if (due_wr == due_rd)
            begin
                report_mismatch("unexpected result beat", 0, 0);
            end
            else
            begin
                want = points_due[due_rd];
                due_rd++;
                if (out_data.point_a_x != want.point_a_x)
                    report_mismatch("point_a_x", out_data.point_a_x, want.point_a_x);
                if (out_data.point_a_y != want.point_a_y)
                    report_mismatch("point_a_y", out_data.point_a_y, want.point_a_y);
                if (out_data.point_b_x != want.point_b_x)
                    report_mismatch("point_b_x", out_data.point_b_x, want.point_b_x);
                if (out_data.point_b_y != want.point_b_y)
                    report_mismatch("point_b_y", out_data.point_b_y, want.point_b_y);
                if (out_data.fix_status != want.fix_status)
                    report_mismatch("fix_status", out_data.fix_status, want.fix_status);
            end
        end
    end

    // receiver stalls
    initial
    begin
        int run;
        out_stall = 1'b0;
        forever
        begin
            @(negedge clk);
            if (hold_off)
            begin
                out_stall <= 1'b1;
                repeat (300)
                begin
                    @(negedge clk);
                end
                hold_off = 1'b0;
                out_stall <= 1'b0;
            end
            else if (stall_enable && $urandom_range(0, 3) == 0)
            begin
                run = random_gap() + 1;
                out_stall <= 1'b1;
                repeat (run)
                begin
                    @(negedge clk);
                end
                out_stall <= 1'b0;
            end
        end
    end

    // watchdog on accepted beats
    always @(posedge clk)
    begin
        if ((in_valid && !in_stall) || (out_valid && !out_stall) || cfg_write)
        begin
            idle_cycles <= 0;
        end
        else
        begin
            idle_cycles <= idle_cycles + 1;
        end
        if (idle_cycles >= WDOG_LIMIT)
        begin
            $display("CHECK FAILED");
            $finish;
        end
    end

    initial
    begin
        clk          = 1'b0;
        rst_n        = 1'b0;
        in_valid     = 1'b0;
        in_data      = '0;
        cfg_write    = 1'b0;
        cfg_index    = '0;
        cfg_data     = '0;
        due_wr       = 0;
        due_rd       = 0;
        mismatches   = 0;
        idle_cycles  = 0;
        hold_off     = 1'b0;
        stall_enable = 1'b0;
        for (int i = 0; i < 4; i++)
        begin
            anchor_x[i] = '0;
            anchor_y[i] = '0;
        end
        repeat (10)
        begin
            @(negedge clk);
        end
        rst_n = 1'b1;
        @(negedge clk);
        // anchors still at reset: coincident centres
        send_beat('{16'd300, 16'd300, 2'd1, 2'd2}, 0);
        wait_drained();
        test_directed();
        stall_enable = 1'b1;
        test_random(6, 150);
        test_backpressure();
        wait_drained();
        if (mismatches == 0)
        begin
            $display("CHECK OK");
        end
        else
        begin
            $display("CHECK FAILED");
        end
        $finish;
    end

endmodule

`default_nettype wire
